// ===== src/dqd_pkg.sv =====
// Shared types and constants for the deque with delete-by-value unit.
`default_nettype none
package dqd_pkg;

  localparam int DEPTH   = 16;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int VALUE_W = 32;
  localparam int MODE_W  = 3;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 5;
  localparam int OP_W    = 3;

  // Request modes
  localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd0;
  localparam logic [MODE_W-1:0] MODE_PUSH_REAR  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_POP_REAR   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_DELETE     = 3'd4;

  // Result status codes
  localparam logic [STAT_W-1:0] STAT_DONE      = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL      = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY     = 2'd2;
  localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd3;

  // Operations broadcast to every cell
  localparam logic [OP_W-1:0] OP_NONE       = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd1;
  localparam logic [OP_W-1:0] OP_PUSH_REAR  = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd3;
  localparam logic [OP_W-1:0] OP_POP_REAR   = 3'd4;
  localparam logic [OP_W-1:0] OP_DELETE     = 3'd5;

  typedef struct packed {
    logic [MODE_W-1:0]         mode;
    logic signed [VALUE_W-1:0] value;
  } in_beat_t;

  typedef struct packed {
    logic [STAT_W-1:0]         status;
    logic [COUNT_W-1:0]        count;
    logic signed [VALUE_W-1:0] front_value;
    logic signed [VALUE_W-1:0] rear_value;
  } out_beat_t;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [VALUE_W-1:0] value;
  } cell_ctl_t;

endpackage
`default_nettype wire

// ===== src/dqd_cell.sv =====
// One storage cell of the deque chain: holds an entry and its valid bit.
`default_nettype none
module dqd_cell
  import dqd_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire cell_ctl_t          ctl,
  input  wire logic [VALUE_W-1:0] left_value,
  input  wire logic               left_valid,
  input  wire logic [VALUE_W-1:0] right_value,
  input  wire logic               right_valid,
  input  wire logic               hit_in,
  output logic                    hit_out,
  output logic [VALUE_W-1:0]      value,
  output logic                    valid
);

  logic [VALUE_W-1:0] value_r;
  logic [VALUE_W-1:0] value_nxt;
  logic               valid_r;
  logic               valid_nxt;
  logic               match;

  assign match   = valid_r && (value_r == ctl.value);
  assign hit_out = hit_in | match;
  assign value   = value_r;
  assign valid   = valid_r;

  always_comb begin
    value_nxt = value_r;
    valid_nxt = valid_r;
    case (ctl.op)
      OP_PUSH_FRONT: begin
        value_nxt = left_value;
        valid_nxt = left_valid;
      end
      OP_PUSH_REAR: begin
        if (!valid_r && left_valid) begin
          value_nxt = ctl.value;
          valid_nxt = 1'b1;
        end
      end
      OP_POP_FRONT: begin
        value_nxt = right_value;
        valid_nxt = right_valid;
      end
      OP_POP_REAR: begin
        if (valid_r && !right_valid) begin
          valid_nxt = 1'b0;
        end
      end
      OP_DELETE: begin
        // close the gap from the first match toward the rear
        if (hit_out) begin
          value_nxt = right_value;
          valid_nxt = right_valid;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

endmodule
`default_nettype wire

// ===== src/deque_with_delete_by_value_unit.sv =====
// Top level of the bounded deque with delete-by-value: cell chain and result register.
`default_nettype none
// Channel  Ports                          Beat contents
// -------  -----------------------------  ------------------------------------------
// input    in_valid, in_ready, in_data    mode, value (push / search value)
// result   out_valid, out_ready, out_data status, count, front_value, rear_value
//
// For each beat the accept edge updates every cell of the chain at once, and
// the next edge loads the result register from the updated cells (front from
// cell 0, rear from the last valid cell). No new item is taken until that
// result is loaded, nor while the result side stalls.
// Reset (rst_n low, synchronous) clears all valid bits, the count and both
// handshake flags; entry contents are not reset.
// A stalled result holds in the output register and blocks new input beats.
module deque_with_delete_by_value_unit
  import dqd_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_beat_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_beat_t      out_data
);

  // chain wiring
  logic [VALUE_W-1:0] cell_value [DEPTH];
  logic               cell_valid [DEPTH];
  logic               hit        [DEPTH+1];
  cell_ctl_t          ctl;

  // control state
  logic               pend_r;
  logic               out_valid_r;
  logic [CNT_W-1:0]   count_r;
  logic [CNT_W-1:0]   count_nxt;
  logic [STAT_W-1:0]  status_r;
  logic [STAT_W-1:0]  status_nxt;
  out_beat_t          out_r;
  logic               accept;
  logic               full;
  logic               empty;
  logic [VALUE_W-1:0] rear_or;

  // Hold new beats while a result is pending or stalled.
  assign in_ready  = !pend_r && (!out_valid_r || out_ready);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign full  = (count_r == CNT_W'(DEPTH));
  assign empty = (count_r == '0);

  assign hit[0] = 1'b0;

  // Decode the request into the chain operation, status and new count.
  // Refused requests (full push, empty pop, missing value) leave the cells unchanged.
  always_comb begin
    ctl.op     = OP_NONE;
    ctl.value  = in_data.value;
    status_nxt = STAT_DONE;
    count_nxt  = count_r;
    case (in_data.mode)
      MODE_PUSH_FRONT, MODE_PUSH_REAR: begin
        if (full) begin
          status_nxt = STAT_FULL;
        end else begin
          ctl.op    = (in_data.mode == MODE_PUSH_FRONT) ? OP_PUSH_FRONT : OP_PUSH_REAR;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      MODE_POP_FRONT, MODE_POP_REAR: begin
        if (empty) begin
          status_nxt = STAT_EMPTY;
        end else begin
          ctl.op    = (in_data.mode == MODE_POP_FRONT) ? OP_POP_FRONT : OP_POP_REAR;
          count_nxt = count_r - CNT_W'(1);
        end
      end
      MODE_DELETE: begin
        // the match chain does not depend on the op, so broadcast delete always
        ctl.op = OP_DELETE;
        if (hit[DEPTH]) begin
          count_nxt = count_r - CNT_W'(1);
        end else begin
          status_nxt = STAT_NOT_FOUND;
        end
      end
      default: begin
      end
    endcase
    if (!accept) begin
      ctl.op = OP_NONE;
    end
  end

  // Build the row of cells; cell 0 is the front.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [VALUE_W-1:0] lv;
    logic               lvld;
    logic [VALUE_W-1:0] rv;
    logic               rvld;

    if (i == 0) begin : g_first
      assign lv   = in_data.value;
      assign lvld = 1'b1;
    end else begin : g_mid_l
      assign lv   = cell_value[i-1];
      assign lvld = cell_valid[i-1];
    end

    if (i == DEPTH-1) begin : g_last
      assign rv   = '0;
      assign rvld = 1'b0;
    end else begin : g_mid_r
      assign rv   = cell_value[i+1];
      assign rvld = cell_valid[i+1];
    end

    dqd_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl         (ctl),
      .left_value  (lv),
      .left_valid  (lvld),
      .right_value (rv),
      .right_valid (rvld),
      .hit_in      (hit[i]),
      .hit_out     (hit[i+1]),
      .value       (cell_value[i]),
      .valid       (cell_valid[i])
    );
  end

  // Pick the rear entry: the valid cell whose rear neighbor is empty.
  always_comb begin
    rear_or = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (cell_valid[i] && ((i == DEPTH-1) || !cell_valid[(i == DEPTH-1) ? i : i+1])) begin
        rear_or = rear_or | cell_value[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      count_r     <= '0;
    end else begin
      if (accept) begin
        count_r <= count_nxt;
      end
      pend_r <= accept;
      // advance the result slot: load after the chain update, drop on take
      if (pend_r) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_nxt;
    end
    if (pend_r) begin
      out_r.status      <= status_r;
      out_r.count       <= COUNT_W'(count_r);
      out_r.front_value <= cell_valid[0] ? cell_value[0] : '0;
      out_r.rear_value  <= rear_or;
    end
  end

endmodule
`default_nettype wire

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the bounded deque with delete-by-value unit.
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import dqd_pkg::*;

  // ---------------------------------------------------------------------------
  // Run parameters
  // ---------------------------------------------------------------------------
  localparam int CLK_PERIOD    = 12;
  localparam int RESET_CYCLES  = 12;
  localparam int STALL_LIMIT   = 2000;  // cycles with no beat moving on either side
  localparam int HOLD_CYCLES   = 120;   // long receiver hold-off
  localparam int SETTLE_CYCLES = 8;     // settle time after the last result comes back
  localparam int FILL_ROUNDS   = 6;
  localparam int RANDOM_ITEMS  = 1240;
  localparam int HOLD_ROUNDS   = 2;
  localparam int HOLD_ITEMS    = 30;

  // Modes the block treats as no-ops
  localparam logic [MODE_W-1:0] MODE_SPARE_LO  = 3'd5;
  localparam logic [MODE_W-1:0] MODE_SPARE_MID = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SPARE_HI  = 3'd7;

  localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'h8000_0000;
  localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'h7FFF_FFFF;

  typedef enum int {BIAS_GROW, BIAS_SHRINK, BIAS_EVEN, BIAS_SEARCH} mix_bias_e;
  typedef enum int {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_BURSTY} rx_pattern_e;

  // ---------------------------------------------------------------------------
  // DUT hookup; every input has a known value from time zero
  // ---------------------------------------------------------------------------
  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  in_beat_t  in_data   = '0;
  logic      out_ready = 1'b0;
  logic      in_ready;
  logic      out_valid;
  out_beat_t out_data;

  wire in_fire  = in_valid && in_ready;
  wire out_fire = out_valid && out_ready;

  deque_with_delete_by_value_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Shadow deque and the results it predicts
  // ---------------------------------------------------------------------------
  logic signed [VALUE_W-1:0] shadow_entries[$];  // index 0 is the front
  out_beat_t                 pending_results[$];

  int mismatches      = 0;
  int items_sent      = 0;
  int results_checked = 0;
  int status_seen[4]  = '{0, 0, 0, 0};

  // Sender burst state; receiver hold-off handshake between processes
  int burst_left    = 0;
  bit gaps_on       = 1'b1;
  int hold_requests = 0;
  int holds_served  = 0;

  // Apply one operation to the shadow deque and return the result it should give.
  function automatic out_beat_t apply_deque_op(input in_beat_t beat);
    out_beat_t res;
    int        hit;
    res        = '0;
    res.status = STAT_DONE;
    hit        = -1;
    case (beat.mode)
      MODE_PUSH_FRONT: begin
        if (shadow_entries.size() >= DEPTH) res.status = STAT_FULL;
        else shadow_entries.push_front(beat.value);
      end
      MODE_PUSH_REAR: begin
        if (shadow_entries.size() >= DEPTH) res.status = STAT_FULL;
        else shadow_entries.push_back(beat.value);
      end
      MODE_POP_FRONT: begin
        if (shadow_entries.size() == 0) res.status = STAT_EMPTY;
        else void'(shadow_entries.pop_front());
      end
      MODE_POP_REAR: begin
        if (shadow_entries.size() == 0) res.status = STAT_EMPTY;
        else void'(shadow_entries.pop_back());
      end
      MODE_DELETE: begin
        // Only the match nearest the front goes; the rest close up behind it.
        for (int i = 0; i < shadow_entries.size(); i++)
          if (hit < 0 && shadow_entries[i] == beat.value) hit = i;
        if (hit < 0) res.status = STAT_NOT_FOUND;
        else shadow_entries.delete(hit);
      end
      default: ;
    endcase
    res.count = COUNT_W'(shadow_entries.size());
    if (shadow_entries.size() != 0) begin
      res.front_value = shadow_entries[0];
      res.rear_value  = shadow_entries[shadow_entries.size() - 1];
    end
    status_seen[res.status]++;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic in_beat_t make_beat(input logic [MODE_W-1:0] mode,
                                         input logic signed [VALUE_W-1:0] value);
    in_beat_t beat;
    beat.mode  = mode;
    beat.value = value;
    return beat;
  endfunction

  // Values lean on a small pool so that deletes find duplicates and hits.
  function automatic logic signed [VALUE_W-1:0] pick_value();
    int unsigned               sel;
    logic signed [VALUE_W-1:0] v;
    sel = $urandom_range(0, 15);
    if (sel < 6) begin
      v = $urandom_range(0, 6);
      v = v - 3;
    end else if (sel == 6) v = VAL_MIN;
    else if (sel == 7) v = VAL_MAX;
    else v = $urandom;
    return v;
  endfunction

  // Draw one operation, weighted so the occupancy drifts the way the bias asks.
  function automatic in_beat_t random_beat(input mix_bias_e bias);
    int unsigned       roll;
    int unsigned       push_pct;
    int unsigned       pop_pct;
    logic [MODE_W-1:0] mode;
    logic signed [VALUE_W-1:0] value;
    case (bias)
      BIAS_GROW:   begin push_pct = 70; pop_pct = 15; end
      BIAS_SHRINK: begin push_pct = 20; pop_pct = 65; end
      BIAS_EVEN:   begin push_pct = 40; pop_pct = 40; end
      default:     begin push_pct = 30; pop_pct = 20; end
    endcase
    value = pick_value();
    roll  = $urandom_range(0, 99);
    if (roll < 4) begin
      case ($urandom_range(0, 2))
        0:       mode = MODE_SPARE_LO;
        1:       mode = MODE_SPARE_MID;
        default: mode = MODE_SPARE_HI;
      endcase
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < push_pct)
        mode = $urandom_range(0, 1) ? MODE_PUSH_FRONT : MODE_PUSH_REAR;
      else if (roll < push_pct + pop_pct)
        mode = $urandom_range(0, 1) ? MODE_POP_FRONT : MODE_POP_REAR;
      else begin
        mode = MODE_DELETE;
        // Mostly search for something that is really held, at any position.
        if (shadow_entries.size() != 0 && $urandom_range(0, 2) != 0)
          value = shadow_entries[$urandom_range(0, shadow_entries.size() - 1)];
      end
    end
    return make_beat(mode, value);
  endfunction

  // Drop valid and let the sender idle; an argument of zero is a no-op.
  task automatic pause_sender(input int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Offer one beat and hold it until accepted; predict at the accept edge.
  // Called at a rising edge; valid stays high into the next beat when chained.
  task automatic send_beat(input in_beat_t beat);
    in_valid <= 1'b1;
    in_data  <= beat;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(apply_deque_op(beat));
    items_sent++;
  endtask

  // Send in bursts of random length, with random gaps between bursts while gaps_on is set.
  task automatic offer_beat(input in_beat_t beat);
    if (burst_left == 0) begin
      if (gaps_on) pause_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    send_beat(beat);
  endtask

  // Stop sending until every predicted result has come back, then settle.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic report_mismatch(input string what, input logic [79:0] got,
                                 input logic [79:0] want);
    $display("MISMATCH @%0t: %s got %0h want %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------------
  // Result checker: compare each accepted result with the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    out_beat_t want;
    if (rst_n && out_fire) begin
      results_checked++;
      if (pending_results.size() == 0) begin
        report_mismatch("result with no item pending", 80'(out_data), '0);
      end else begin
        want = pending_results.pop_front();
        if (out_data.status !== want.status)
          report_mismatch("status", 80'(out_data.status), 80'(want.status));
        if (out_data.count !== want.count)
          report_mismatch("count", 80'(out_data.count), 80'(want.count));
        if (out_data.front_value !== want.front_value)
          report_mismatch("front_value", 80'(unsigned'(out_data.front_value)),
                          80'(unsigned'(want.front_value)));
        if (out_data.rear_value !== want.rear_value)
          report_mismatch("rear_value", 80'(unsigned'(out_data.rear_value)),
                          80'(unsigned'(want.rear_value)));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: switch between stall patterns; serve long hold-off requests
  // ---------------------------------------------------------------------------
  int          rx_hold_left  = 0;
  int          rx_phase_left = 0;
  int unsigned rx_tick       = 0;
  rx_pattern_e rx_pattern    = RX_ALWAYS;

  always @(posedge clk) begin
    if (holds_served != hold_requests) begin
      holds_served++;
      rx_hold_left = HOLD_CYCLES;
    end
    if (rx_hold_left > 0) begin
      // Hold off; the output register fills and the input side backs up.
      rx_hold_left--;
      out_ready <= 1'b0;
    end else begin
      if (rx_phase_left == 0) begin
        rx_pattern    = rx_pattern_e'($urandom_range(0, 3));
        rx_phase_left = $urandom_range(30, 200);
      end
      rx_phase_left--;
      rx_tick++;
      case (rx_pattern)
        RX_ALWAYS: out_ready <= 1'b1;
        RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
        RX_SPARSE: out_ready <= ($urandom_range(0, 4) == 0);
        default:   out_ready <= ((rx_tick % 8) < 5);
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: end the run if no beat moves for too long
  // ---------------------------------------------------------------------------
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || in_fire || out_fire) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("watchdog: no beat moved for %0d cycles", STALL_LIMIT);
    $display("tb failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Pops, delete and spare modes on an empty deque.
  task automatic test_empty_ops();
    offer_beat(make_beat(MODE_POP_FRONT, pick_value()));
    offer_beat(make_beat(MODE_POP_REAR, pick_value()));
    offer_beat(make_beat(MODE_DELETE, pick_value()));
    offer_beat(make_beat(MODE_SPARE_LO, VAL_MAX));
    offer_beat(make_beat(MODE_SPARE_HI, VAL_MIN));
    drain_results();
  endtask

  // Extreme values at both ends, duplicate delete, near-miss search, spare mode.
  task automatic test_extreme_values();
    offer_beat(make_beat(MODE_PUSH_FRONT, VAL_MIN));
    offer_beat(make_beat(MODE_PUSH_REAR, VAL_MAX));
    offer_beat(make_beat(MODE_PUSH_FRONT, -32'sd1));
    offer_beat(make_beat(MODE_PUSH_REAR, 32'sd0));
    offer_beat(make_beat(MODE_PUSH_REAR, -32'sd1));
    offer_beat(make_beat(MODE_SPARE_MID, -32'sd1));
    // Two copies of -1: only the front one goes.
    offer_beat(make_beat(MODE_DELETE, -32'sd1));
    // Differs from a held entry in the low bit only.
    offer_beat(make_beat(MODE_DELETE, 32'h7FFF_FFFE));
    // Hit in the middle; the tail closes up.
    offer_beat(make_beat(MODE_DELETE, VAL_MAX));
    offer_beat(make_beat(MODE_POP_FRONT, 32'sd0));
    offer_beat(make_beat(MODE_POP_REAR, 32'sd0));
    offer_beat(make_beat(MODE_DELETE, 32'sd0));
    offer_beat(make_beat(MODE_DELETE, 32'sd0));
    drain_results();
  endtask

  // Fill to the limit, push past it, delete held entries, drain past empty.
  task automatic test_fill_and_drain();
    for (int r = 0; r < FILL_ROUNDS; r++) begin
      gaps_on = (r % 2 == 0);
      while (shadow_entries.size() < DEPTH)
        offer_beat(make_beat($urandom_range(0, 1) ? MODE_PUSH_FRONT : MODE_PUSH_REAR,
                             pick_value()));
      repeat (3)
        offer_beat(make_beat($urandom_range(0, 1) ? MODE_PUSH_FRONT : MODE_PUSH_REAR,
                             pick_value()));
      repeat (4)
        offer_beat(make_beat(MODE_DELETE,
                             shadow_entries[$urandom_range(0, shadow_entries.size() - 1)]));
      offer_beat(make_beat(MODE_DELETE, $urandom));
      while (shadow_entries.size() != 0)
        offer_beat(make_beat($urandom_range(0, 1) ? MODE_POP_FRONT : MODE_POP_REAR,
                             pick_value()));
      offer_beat(make_beat(MODE_POP_FRONT, pick_value()));
      offer_beat(make_beat(MODE_POP_REAR, pick_value()));
      offer_beat(make_beat(MODE_DELETE, pick_value()));
    end
    gaps_on = 1'b1;
    drain_results();
  endtask

  // Long random mix in phases of differing bias and sender behavior.
  task automatic test_random_mix();
    int        left;
    int        phase_len;
    mix_bias_e bias;
    left = RANDOM_ITEMS;
    while (left > 0) begin
      phase_len = $urandom_range(20, 80);
      if (phase_len > left) phase_len = left;
      bias    = mix_bias_e'($urandom_range(0, 3));
      gaps_on = ($urandom_range(0, 3) != 0);
      repeat (phase_len) offer_beat(random_beat(bias));
      left -= phase_len;
      // Now and then let everything come back before going on.
      if ($urandom_range(0, 5) == 0) drain_results();
    end
    gaps_on = 1'b1;
    drain_results();
  endtask

  // Hold the receiver off while the sender keeps offering back to back.
  task automatic test_backpressure();
    for (int r = 0; r < HOLD_ROUNDS; r++) begin
      gaps_on = 1'b0;
      hold_requests++;
      repeat (HOLD_ITEMS) offer_beat(random_beat(r == 0 ? BIAS_GROW : BIAS_EVEN));
      drain_results();
    end
    gaps_on = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_ops();
    test_extreme_values();
    test_fill_and_drain();
    test_backpressure();
    test_random_mix();

    drain_results();
    if (pending_results.size() != 0)
      report_mismatch("items left without a result", 80'(pending_results.size()), '0);

    $display("covered %0d items, %0d results: %0d full drops, %0d empty pops, %0d misses",
             items_sent, results_checked, status_seen[STAT_FULL], status_seen[STAT_EMPTY],
             status_seen[STAT_NOT_FOUND]);
    $display("with %0d long receiver hold-offs and %0d mismatches", holds_served, mismatches);
    if (mismatches == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
